/* hdl/smscan_pkg.sv */
package smscan_pkg;

   localparam int MARK_LEN = 16;
   localparam int WIN_LEN  = 15;
   localparam int NAME_W   = 5;

   localparam logic [7:0] START_MARK [MARK_LEN] = '{
      8'h5F, 8'h5F, 8'h5F, 8'h49, 8'h41, 8'h4D, 8'h50, 8'h52,
      8'h4F, 8'h47, 8'h52, 8'h41, 8'h4D, 8'h5F, 8'h5F, 8'h5F };
   localparam logic [7:0] END_MARK [MARK_LEN] = '{
      8'h5F, 8'h5F, 8'h5F, 8'h45, 8'h4E, 8'h44, 8'h50, 8'h52,
      8'h4F, 8'h47, 8'h52, 8'h41, 8'h4D, 8'h5F, 8'h5F, 8'h5F };

   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_NAME  = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;
   localparam logic [1:0] KIND_ERROR = 2'd3;

   localparam logic        REG_SECTOR_LIMIT   = 1'b0;
   localparam logic [15:0] SECTOR_LIMIT_RESET = 16'd100;

   typedef struct packed {
      logic start_hit;
      logic stop_hit;
   } smscan_hit_type;

endpackage

/* hdl/start_end_marker_scanner.sv */
// channel   direction  handshake              payload
// req       in         req_valid/req_stall    disk_byte, read_failed
// rsp       out        rsp_valid/rsp_stall    kind, sector_number, marker_offset,
//                                             entry_index, name_char, name_pos, last
// csr       in         psel/penable/pready    paddr, pwdata, prdata (sector_limit)
//
// One item per cycle: a row of 15 byte cells shifts the window while the 16th byte
// is compared in parallel. An item gives up to two results, which go into a
// four-entry result queue; req_stall is high while it has fewer than two free
// entries, so the sustained rate is one item per cycle when results are one or none
// and the output side runs at one result per cycle. Reset is synchronous and clears
// the window and all scan state; sector_limit returns to 100.
module start_end_marker_scanner #(
   parameter int SECTOR_BYTES = 512,
   parameter int NAME_BYTES   = 19
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_disk_byte,
   input  logic                            req_read_failed,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_kind,
   output logic [15:0]                     rsp_sector_number,
   output logic [$clog2(SECTOR_BYTES)-1:0] rsp_marker_offset,
   output logic [7:0]                      rsp_entry_index,
   output logic [7:0]                      rsp_name_char,
   output logic [4:0]                      rsp_name_pos,
   output logic                            rsp_last,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [2:0]                      paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   import smscan_pkg::*;

   localparam int POS_W = $clog2(SECTOR_BYTES);
   localparam logic [POS_W-1:0]  POS_LAST   = POS_W'(SECTOR_BYTES - 1);
   localparam logic [POS_W-1:0]  POS_WIN    = POS_W'(WIN_LEN);
   localparam logic [NAME_W-1:0] NAME_COUNT = NAME_W'(NAME_BYTES);

   typedef struct packed {
      logic [1:0]       kind;
      logic [15:0]      sector_number;
      logic [POS_W-1:0] marker_offset;
      logic [7:0]       entry_index;
      logic [7:0]       name_char;
      logic [NAME_W-1:0] name_pos;
      logic             last;
   } rsp_type;

   localparam int RSP_W = $bits(rsp_type);

   // configuration
   logic [15:0] sector_limit_ff;
   logic        csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == REG_SECTOR_LIMIT) ? 32'(sector_limit_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         sector_limit_ff <= SECTOR_LIMIT_RESET;
      end else if (csr_write && paddr[2] == REG_SECTOR_LIMIT) begin
         sector_limit_ff <= pwdata[15:0];
      end
   end

   // scan state
   logic [POS_W-1:0]  byte_pos_ff, byte_pos_in;
   logic [15:0]       sector_ff, sector_in;
   logic              inside_ff, inside_in;
   logic              skip_ff, skip_in;
   logic [NAME_W-1:0] name_left_ff, name_left_in;
   logic [7:0]        count_ff, count_in;
   logic [7:0]        owner_ff, owner_in;
   logic              stopped_ff, stopped_in;

   logic accept, halted, active, step, wrap;
   logic name_pend, start_now, stop_now, search;
   logic room2;
   rsp_type r0, r1;
   logic push0, push1;

   // window cells: cell 0 holds the oldest byte
   logic [7:0]     win_w [WIN_LEN+1];
   smscan_hit_type hit_w [WIN_LEN];
   logic [WIN_LEN-1:0] start_vec, stop_vec;

   assign win_w[WIN_LEN] = req_disk_byte;

   for (genvar k = 0; k < WIN_LEN; k++) begin : g_cell
      smscan_cell #(.INDEX(k)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift    (step),
         .clear    (step && wrap),
         .byte_in  (win_w[k+1]),
         .byte_out (win_w[k]),
         .hit      (hit_w[k])
      );
      assign start_vec[k] = hit_w[k].start_hit;
      assign stop_vec[k]  = hit_w[k].stop_hit;
   end

   assign req_stall = !room2;
   assign accept    = req_valid && !req_stall;
   assign halted    = stopped_ff || (sector_ff >= sector_limit_ff);
   assign active    = accept && !halted;
   assign step      = active && !req_read_failed;
   assign wrap      = (byte_pos_ff == POS_LAST);
   assign name_pend = (name_left_ff != '0);
   assign search    = (byte_pos_ff >= POS_WIN) && !skip_ff;
   assign start_now = search && !inside_ff && (&start_vec)
                      && (req_disk_byte == START_MARK[WIN_LEN]);
   assign stop_now  = search && inside_ff && (&stop_vec)
                      && (req_disk_byte == END_MARK[WIN_LEN]);

   always_comb begin
      byte_pos_in  = byte_pos_ff;
      sector_in    = sector_ff;
      inside_in    = inside_ff;
      skip_in      = skip_ff;
      name_left_in = name_left_ff;
      count_in     = count_ff;
      owner_in     = owner_ff;
      stopped_in   = stopped_ff;
      if (active && req_read_failed) begin
         stopped_in = 1'b1;
      end else if (step) begin
         if (name_pend) begin
            name_left_in = name_left_ff - NAME_W'(1);
         end
         if (start_now) begin
            inside_in    = 1'b1;
            skip_in      = 1'b1;
            name_left_in = NAME_COUNT;
            owner_in     = count_ff;
         end else if (stop_now) begin
            inside_in = 1'b0;
            if (count_ff != 8'hFF) begin
               count_in = count_ff + 8'd1;
            end
         end
         if (wrap) begin
            byte_pos_in = '0;
            skip_in     = 1'b0;
            sector_in   = sector_ff + 16'd1;
            if (sector_in >= sector_limit_ff) begin
               stopped_in = 1'b1;
            end
         end else begin
            byte_pos_in = byte_pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff  <= '0;
         sector_ff    <= '0;
         inside_ff    <= 1'b0;
         skip_ff      <= 1'b0;
         name_left_ff <= '0;
         count_ff     <= '0;
         owner_ff     <= '0;
         stopped_ff   <= 1'b0;
      end else begin
         byte_pos_ff  <= byte_pos_in;
         sector_ff    <= sector_in;
         inside_ff    <= inside_in;
         skip_ff      <= skip_in;
         name_left_ff <= name_left_in;
         count_ff     <= count_in;
         owner_ff     <= owner_in;
         stopped_ff   <= stopped_in;
      end
   end

   // result building: name byte goes ahead of a marker on the same item
   always_comb begin
      rsp_type marker;
      rsp_type name;
      marker = '0;
      marker.kind          = start_now ? KIND_START : KIND_END;
      marker.sector_number = sector_ff;
      marker.marker_offset = byte_pos_ff - POS_WIN;
      marker.entry_index   = count_ff;
      marker.last          = 1'b1;
      name = '0;
      name.kind        = KIND_NAME;
      name.entry_index = owner_ff;
      name.name_char   = req_disk_byte;
      name.name_pos    = NAME_COUNT - name_left_ff;
      name.last        = !(start_now || stop_now);
      r0 = '0;
      r1 = marker;
      if (req_read_failed) begin
         r0.kind          = KIND_ERROR;
         r0.sector_number = sector_ff;
         r0.entry_index   = count_ff;
         r0.last          = 1'b1;
      end else if (name_pend) begin
         r0 = name;
      end else begin
         r0 = marker;
      end
      push0 = active && (req_read_failed || name_pend || start_now || stop_now);
      push1 = step && name_pend && (start_now || stop_now);
   end

   rsp_type q_out;
   logic [RSP_W-1:0] q_data;

   smscan_rsp_fifo #(.DATA_W(RSP_W)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push0     (push0),
      .data0     (r0),
      .push1     (push1),
      .data1     (r1),
      .room2     (room2),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (q_data)
   );

   assign q_out             = q_data;
   assign rsp_kind          = q_out.kind;
   assign rsp_sector_number = q_out.sector_number;
   assign rsp_marker_offset = q_out.marker_offset;
   assign rsp_entry_index   = q_out.entry_index;
   assign rsp_name_char     = q_out.name_char;
   assign rsp_name_pos      = q_out.name_pos;
   assign rsp_last          = q_out.last;

endmodule

/* hdl/smscan_cell.sv */
module smscan_cell #(
   parameter int INDEX = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      shift,
   input  logic                      clear,
   input  logic [7:0]                byte_in,
   output logic [7:0]                byte_out,
   output smscan_pkg::smscan_hit_type hit
);
   import smscan_pkg::*;

   logic [7:0] byte_ff;
   logic [7:0] byte_in_w;

   always_comb begin
      byte_in_w = byte_ff;
      if (clear) begin
         byte_in_w = 8'd0;
      end else if (shift) begin
         byte_in_w = byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= 8'd0;
      end else begin
         byte_ff <= byte_in_w;
      end
   end

   assign byte_out      = byte_ff;
   assign hit.start_hit = (byte_ff == START_MARK[INDEX]);
   assign hit.stop_hit  = (byte_ff == END_MARK[INDEX]);

endmodule

/* hdl/smscan_rsp_fifo.sv */
module smscan_rsp_fifo #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push0,
   input  logic [DATA_W-1:0] data0,
   input  logic              push1,
   input  logic [DATA_W-1:0] data1,
   output logic              room2,
   output logic              out_valid,
   input  logic              out_stall,
   output logic [DATA_W-1:0] out_data
);
   import smscan_pkg::*;

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = PTR_W + 1;

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              pop;
   logic [CNT_W-1:0]  n_push;

   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && !out_stall;
   assign room2     = (count_ff <= CNT_W'(DEPTH - 2));

   always_comb begin
      n_push    = CNT_W'(push0) + CNT_W'(push1);
      wr_ptr_in = wr_ptr_ff + PTR_W'(n_push);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + n_push - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push0) begin
         mem_ff[wr_ptr_ff] <= data0;
      end
      if (push1) begin
         mem_ff[wr_ptr_ff + PTR_W'(1)] <= data1;
      end
   end

endmodule

/* tb/smscan_checker.sv */
module smscan_checker #(
   parameter int SECTOR_BYTES = 512,
   parameter int NAME_BYTES   = 19
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [7:0]                      req_disk_byte,
   input  logic                            req_read_failed,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [1:0]                      rsp_kind,
   input  logic [15:0]                     rsp_sector_number,
   input  logic [$clog2(SECTOR_BYTES)-1:0] rsp_marker_offset,
   input  logic [7:0]                      rsp_entry_index,
   input  logic [7:0]                      rsp_name_char,
   input  logic [4:0]                      rsp_name_pos,
   input  logic                            rsp_last,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic                            pready,
   input  logic [2:0]                      paddr,
   input  logic [31:0]                     pwdata,
   output int                              failures,
   output int                              pending
);
   import smscan_pkg::*;

   localparam int OFF_W = $clog2(SECTOR_BYTES);
   localparam logic [2:0] SECTOR_LIMIT_ADDR = 3'(4 * REG_SECTOR_LIMIT);

   typedef struct packed {
      logic [1:0]       kind;
      logic [15:0]      sector;
      logic [OFF_W-1:0] offset;
      logic [7:0]       entry;
      logic [7:0]       name_char;
      logic [4:0]       name_pos;
      logic             last;
   } scan_result_t;

   scan_result_t expected_scan_results [$];

   logic [15:0] sector_limit;
   logic [7:0]  window [WIN_LEN];
   int          byte_pos;
   int          sector_cnt;
   bit          in_program;
   bit          skip_sector;
   int          name_left;
   logic [7:0]  entries;
   logic [7:0]  name_owner;
   bit          halted;

   task automatic report_mismatch(input string msg);
      if (failures < 50)
         $display("[%0t] scan mismatch: %s", $time, msg);
      failures++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   task automatic scan_disk_byte(input logic [7:0] b, input logic fail);
      scan_result_t found [2];
      int n;
      bit start_hit;
      bit end_hit;
      n = 0;
      if (halted || sector_cnt >= int'(sector_limit))
         return;

      if (fail) begin
         found[0] = '0;
         found[0].kind = KIND_ERROR;
         found[0].sector = 16'(sector_cnt);
         found[0].entry = entries;
         found[0].last = 1'b1;
         expected_scan_results.push_back(found[0]);
         halted = 1;
         return;
      end

      // the name byte goes out ahead of a marker found on the same item
      if (name_left > 0) begin
         found[n] = '0;
         found[n].kind = KIND_NAME;
         found[n].entry = name_owner;
         found[n].name_char = b;
         found[n].name_pos = 5'(NAME_BYTES - name_left);
         n++;
         name_left--;
      end

      if (byte_pos >= WIN_LEN && !skip_sector) begin
         start_hit = (b == START_MARK[WIN_LEN]);
         end_hit = (b == END_MARK[WIN_LEN]);
         for (int k = 0; k < WIN_LEN; k++) begin
            if (window[k] != START_MARK[k]) start_hit = 0;
            if (window[k] != END_MARK[k]) end_hit = 0;
         end
         if (!in_program && start_hit) begin
            found[n] = '0;
            found[n].kind = KIND_START;
            found[n].sector = 16'(sector_cnt);
            found[n].offset = OFF_W'(byte_pos - WIN_LEN);
            found[n].entry = entries;
            n++;
            in_program = 1;
            skip_sector = 1;
            name_left = NAME_BYTES;
            name_owner = entries;
         end else if (in_program && end_hit) begin
            found[n] = '0;
            found[n].kind = KIND_END;
            found[n].sector = 16'(sector_cnt);
            found[n].offset = OFF_W'(byte_pos - WIN_LEN);
            found[n].entry = entries;
            n++;
            in_program = 0;
            if (entries != 8'd255) entries++;
         end
      end

      for (int k = 0; k < WIN_LEN - 1; k++)
         window[k] = window[k + 1];
      window[WIN_LEN - 1] = b;

      byte_pos++;
      if (byte_pos >= SECTOR_BYTES) begin
         byte_pos = 0;
         skip_sector = 0;
         for (int k = 0; k < WIN_LEN; k++)
            window[k] = '0;
         sector_cnt++;
         if (sector_cnt >= int'(sector_limit)) halted = 1;
      end

      if (n > 0) found[n - 1].last = 1'b1;
      for (int i = 0; i < n; i++)
         expected_scan_results.push_back(found[i]);
   endtask

   always @(posedge clock) begin
      scan_result_t want;
      if (reset) begin
         expected_scan_results.delete();
         failures = 0;
         sector_limit = SECTOR_LIMIT_RESET;
         for (int k = 0; k < WIN_LEN; k++)
            window[k] = '0;
         byte_pos = 0;
         sector_cnt = 0;
         in_program = 0;
         skip_sector = 0;
         name_left = 0;
         entries = '0;
         name_owner = '0;
         halted = 0;
      end else begin
         if (psel && penable && pwrite && pready && paddr == SECTOR_LIMIT_ADDR)
            sector_limit = pwdata[15:0];
         if (req_valid && !req_stall)
            scan_disk_byte(req_disk_byte, req_read_failed);
         if (rsp_valid && !rsp_stall) begin
            if (expected_scan_results.size() == 0) begin
               report_mismatch("result with none expected");
            end else begin
               want = expected_scan_results.pop_front();
               check_field("kind", 16'(rsp_kind), 16'(want.kind));
               check_field("sector_number", rsp_sector_number, want.sector);
               check_field("marker_offset", 16'(rsp_marker_offset), 16'(want.offset));
               check_field("entry_index", 16'(rsp_entry_index), 16'(want.entry));
               check_field("name_char", 16'(rsp_name_char), 16'(want.name_char));
               check_field("name_pos", 16'(rsp_name_pos), 16'(want.name_pos));
               check_field("last", 16'(rsp_last), 16'(want.last));
            end
         end
      end
      pending = expected_scan_results.size();
   end

endmodule

/* tb/tb.sv */
module tb;
   import smscan_pkg::*;

   localparam int SECTOR_BYTES       = 512;
   localparam int NAME_BYTES         = 19;
   localparam int CYCLE_LIMIT        = 5_000_000;
   localparam int DRAIN_CYCLES       = 12;
   localparam int RANDOM_ITEMS       = 1350;
   localparam logic [2:0] SECTOR_LIMIT_ADDR = 3'(4 * REG_SECTOR_LIMIT);

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic [7:0]  req_disk_byte = '0;
   logic        req_read_failed = 1'b0;
   logic        rsp_stall = 1'b0;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;

   logic                            req_stall;
   logic                            rsp_valid;
   logic [1:0]                      rsp_kind;
   logic [15:0]                     rsp_sector_number;
   logic [$clog2(SECTOR_BYTES)-1:0] rsp_marker_offset;
   logic [7:0]                      rsp_entry_index;
   logic [7:0]                      rsp_name_char;
   logic [4:0]                      rsp_name_pos;
   logic                            rsp_last;
   logic [31:0]                     prdata;
   logic                            pready;

   int failures;
   int pending;

   bit req_quiet = 0;
   bit rsp_quiet = 0;
   bit scan_live = 1;
   int stream_pos = 0;
   int items_sent = 0;
   int stall_left = 0;
   int cycles = 0;

   start_end_marker_scanner #(
      .SECTOR_BYTES(SECTOR_BYTES),
      .NAME_BYTES(NAME_BYTES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_disk_byte(req_disk_byte),
      .req_read_failed(req_read_failed),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind),
      .rsp_sector_number(rsp_sector_number),
      .rsp_marker_offset(rsp_marker_offset),
      .rsp_entry_index(rsp_entry_index),
      .rsp_name_char(rsp_name_char),
      .rsp_name_pos(rsp_name_pos),
      .rsp_last(rsp_last),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   smscan_checker #(
      .SECTOR_BYTES(SECTOR_BYTES),
      .NAME_BYTES(NAME_BYTES)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_disk_byte(req_disk_byte),
      .req_read_failed(req_read_failed),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind),
      .rsp_sector_number(rsp_sector_number),
      .rsp_marker_offset(rsp_marker_offset),
      .rsp_entry_index(rsp_entry_index),
      .rsp_name_char(rsp_name_char),
      .rsp_name_pos(rsp_name_pos),
      .rsp_last(rsp_last),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .pready(pready),
      .paddr(paddr),
      .pwdata(pwdata),
      .failures(failures),
      .pending(pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[start_end_marker_scanner] ERROR");
         $finish;
      end
   end

   function automatic int gap_len(input bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = gap_len(rsp_quiet);
      end
   end

   // called at a falling edge, returns at a falling edge with valid still high
   task automatic send_item(input logic [7:0] b, input logic fail);
      int gap;
      gap = gap_len(req_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_disk_byte <= b;
      req_read_failed <= fail;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      if (scan_live && !fail) stream_pos++;
      items_sent++;
   endtask

   task automatic send_random_byte();
      send_item(8'($urandom_range(0, 255)), 1'b0);
   endtask

   task automatic send_mark(input bit is_end);
      for (int k = 0; k < MARK_LEN; k++)
         send_item(is_end ? END_MARK[k] : START_MARK[k], 1'b0);
   endtask

   task automatic send_bad_mark(input bit is_end);
      int idx;
      logic [7:0] b;
      idx = $urandom_range(0, MARK_LEN - 1);
      for (int k = 0; k < MARK_LEN; k++) begin
         b = is_end ? END_MARK[k] : START_MARK[k];
         if (k == idx) b = b ^ 8'($urandom_range(1, 255));
         send_item(b, 1'b0);
      end
   endtask

   task automatic fill_to(input int target);
      while (stream_pos < target) send_random_byte();
   endtask

   task automatic fill_to_offset(input int off);
      int target;
      target = (stream_pos / SECTOR_BYTES) * SECTOR_BYTES + off;
      if (target < stream_pos) target += SECTOR_BYTES;
      fill_to(target);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_sector_limit(input logic [31:0] value);
      drain();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= SECTOR_LIMIT_ADDR;
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   initial begin
      int base;
      int choice;
      bit paused_once;
      paused_once = 0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      write_sector_limit(32'd65535);

      // start at offset 0, name with extreme bytes, then an end inside the skipped rest
      send_mark(0);
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      repeat (NAME_BYTES - 2) send_random_byte();
      send_mark(1);
      // end at the last offset that fits in a sector
      fill_to(SECTOR_BYTES + 496);
      send_mark(1);
      // end while not inside a program, then a start that straddles a sector boundary
      fill_to(2 * SECTOR_BYTES);
      send_mark(1);
      fill_to(2 * SECTOR_BYTES + 500);
      send_mark(0);
      // start at the last offset: its name runs into the next sector, where an end
      // marker overlaps the name bytes
      fill_to(3 * SECTOR_BYTES + 496);
      send_mark(0);
      send_mark(1);
      fill_to(4 * SECTOR_BYTES + 100);
      send_bad_mark(0);
      fill_to(4 * SECTOR_BYTES + 200);
      send_mark(0);
      repeat (25) send_random_byte();

      // limit below the current sector: everything is ignored until it is raised
      write_sector_limit(32'd1);
      scan_live = 0;
      repeat (20) send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      scan_live = 1;
      write_sector_limit(32'd65535);

      write_sector_limit(32'(stream_pos / SECTOR_BYTES + 8));
      base = items_sent;
      while (items_sent - base < RANDOM_ITEMS) begin
         if (!paused_once && items_sent - base >= RANDOM_ITEMS / 2) begin
            drain();
            paused_once = 1;
         end
         choice = $urandom_range(0, 99);
         if (choice < 4) begin
            req_quiet = ($urandom_range(0, 3) == 0);
            rsp_quiet = ($urandom_range(0, 3) == 0);
         end else if (choice < 30) begin
            send_mark(0);
         end else if (choice < 52) begin
            send_mark(1);
         end else if (choice < 62) begin
            send_bad_mark(1'($urandom_range(0, 1)));
         end else if (choice < 74) begin
            repeat ($urandom_range(1, 40)) send_random_byte();
         end else if (choice < 80) begin
            fill_to_offset($urandom_range(497, SECTOR_BYTES - 1));
            send_mark(1'($urandom_range(0, 1)));
         end else if (choice < 86) begin
            fill_to_offset($urandom_range(470, 496));
            send_mark(1'($urandom_range(0, 1)));
         end else if (choice < 94) begin
            repeat ($urandom_range(1, 6)) send_item(START_MARK[0], 1'b0);
            send_mark(1'($urandom_range(0, 1)));
         end else if (choice < 98) begin
            // bytes drawn from the marker alphabet give many partial matches
            repeat ($urandom_range(1, 30))
               send_item($urandom_range(0, 1) ? START_MARK[$urandom_range(0, 15)]
                                              : END_MARK[$urandom_range(0, 15)], 1'b0);
         end else begin
            drain();
         end
      end

      req_quiet = 0;
      rsp_quiet = 0;
      send_random_byte();
      send_item(8'($urandom_range(0, 255)), 1'b1);
      scan_live = 0;
      repeat (8) send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      req_valid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (2 * DRAIN_CYCLES) @(negedge clock);
      if (failures == 0)
         $display("[start_end_marker_scanner] OK");
      else
         $display("[start_end_marker_scanner] ERROR");
      $finish;
   end

endmodule

/* start_end_marker_scanner.f */
hdl/smscan_pkg.sv
hdl/smscan_cell.sv
hdl/smscan_rsp_fifo.sv
hdl/start_end_marker_scanner.sv
tb/smscan_checker.sv
tb/tb.sv
